### rtl/core/skn_pkg.sv
// ============================================================================
// SKINNY-128 CTR keystream package
// Shared types, opcodes, constants and the bit-sliced S-box.
// ============================================================================
`default_nettype none

package skn_pkg;

	localparam int MAX_ROUNDS_DEF = 56;
	localparam logic [5:0] ROUND_COUNT_RESET = 6'd40;

	typedef enum logic [1:0] {
		OP_KEY    = 2'd0,
		OP_CTR_HI = 2'd1,
		OP_CTR_LO = 2'd2,
		OP_DATA   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROUND,
		ST_DONE
	} state_t;

	// Four cipher rows, row 0 in the low word.
	typedef struct packed {
		logic [31:0] r3;
		logic [31:0] r2;
		logic [31:0] r1;
		logic [31:0] r0;
	} rows_t;

	localparam logic [31:0] RC_ROW2 = 32'h0000_0002;

	function automatic logic [31:0] sbox(input logic [31:0] xi);
		logic [31:0] x;
		logic [31:0] y;
		x = xi;
		x = x ^ ((~((x >> 2) | (x >> 3))) & 32'h1111_1111);
		y = (~((x << 5) | (x << 1))) & 32'h2020_2020;
		x = x ^ (((~((x << 5) | (x << 4))) & 32'h4040_4040) ^ y);
		y = (~((x << 2) | (x << 1))) & 32'h8080_8080;
		x = x ^ (((~((x >> 2) | (x << 1))) & 32'h0202_0202) ^ y);
		y = (~((x >> 5) | (x << 1))) & 32'h0404_0404;
		x = x ^ (((~((x >> 1) | (x >> 2))) & 32'h0808_0808) ^ y);
		return ((x & 32'h0808_0808) << 1) |
		       ((x & 32'h3232_3232) << 2) |
		       ((x & 32'h0101_0101) << 5) |
		       ((x & 32'h8080_8080) >> 6) |
		       ((x & 32'h4040_4040) >> 4) |
		       ((x & 32'h0404_0404) >> 2);
	endfunction

	// Byte-reverses a 32-bit word (big-endian counter bytes to a row word).
	function automatic logic [31:0] bswap32(input logic [31:0] w);
		return {w[7:0], w[15:8], w[23:16], w[31:24]};
	endfunction

endpackage

`default_nettype wire

### rtl/core/skn_round.sv
// ============================================================================
// SKINNY-128 round
// One full cipher round: S-box layer, round key and constant, row rotation
// and column mixing.
// ============================================================================
`default_nettype none

module skn_round (
	input  wire skn_pkg::rows_t rows_in,
	input  wire logic [63:0]    round_key,
	output skn_pkg::rows_t      rows_out
);

	logic [31:0] s0, s1, s2, s3;
	logic [31:0] t1, t2, t3;
	logic [31:0] m1, m2;

	always_comb begin
		s0 = skn_pkg::sbox(rows_in.r0) ^ round_key[31:0];
		s1 = skn_pkg::sbox(rows_in.r1) ^ round_key[63:32];
		s2 = skn_pkg::sbox(rows_in.r2) ^ skn_pkg::RC_ROW2;
		s3 = skn_pkg::sbox(rows_in.r3);
		t1 = {s1[23:0], s1[31:24]};
		t2 = {s2[15:0], s2[31:16]};
		t3 = {s3[7:0], s3[31:8]};
		m1 = t1 ^ t2;
		m2 = t2 ^ s0;
		rows_out.r0 = t3 ^ m2;
		rows_out.r1 = s0;
		rows_out.r2 = m1;
		rows_out.r3 = m2;
	end

endmodule

`default_nettype wire

### rtl/core/skinny128_ctr_keystream.sv
// ============================================================================
// SKINNY-128 counter-mode keystream engine
// Round keys live in a single-port-read synchronous memory; a round datapath
// iterates over them once per cycle to encrypt the counter.
// ============================================================================
// Usage:
// The input channel (in_valid / in_stall) carries one item per handshake:
// a round-key load, a counter-half write, or a data byte. Only data bytes
// produce an item on the output channel (out_valid / out_stall).
// Key loads and counter writes restart the keystream. A data byte from a
// live keystream block is answered in the cycle after it is accepted. A
// data byte that needs a fresh block is answered once the round datapath
// has run every round (one round per cycle, keys read from the registered
// key memory) and the block is stored; each block serves 16 bytes.
// While a block is being computed, in_stall is high. A data byte is also
// held off while the output register holds an unread item; key and counter
// items are still taken then. Reset clears the counter to zero, marks the
// keystream as used up and sets round_count to 40; round keys are undefined
// until loaded. A stalled output item holds its value.
// ============================================================================
`default_nettype none

module skinny128_ctr_keystream #(
	parameter int MAX_ROUNDS = skn_pkg::MAX_ROUNDS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [5:0]  cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  opcode,
	input  wire logic [5:0]  key_index,
	input  wire logic [63:0] value,
	input  wire logic [7:0]  data_in,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       data_out
);

	localparam int AW = $clog2(MAX_ROUNDS);
	localparam int CW = $clog2(MAX_ROUNDS + 1);

	skn_pkg::state_t state_q, state_d;

	logic [5:0]    round_count_q;
	logic [63:0]   ctr_hi_q, ctr_lo_q;
	logic [63:0]   ks_lo_q, ks_hi_q;
	logic [4:0]    offset_q;
	logic [7:0]    din_q;
	logic [CW-1:0] round_q;
	logic [CW-1:0] num_rounds;
	skn_pkg::rows_t rows_q, rows_next, ctr_rows;

	logic [63:0]   key_mem [MAX_ROUNDS];
	logic [63:0]   key_rd_q;
	logic [AW-1:0] rd_addr;

	logic          out_valid_q;
	logic [7:0]    data_out_q;

	logic in_acc, out_take, op_data, need_block, key_ok, last_round;
	logic [63:0] ks_word;
	logic [7:0]  ks_byte;

	assign op_data    = opcode == skn_pkg::OP_DATA;
	assign in_acc     = in_valid && !in_stall;
	assign out_take   = out_valid_q && !out_stall;
	assign need_block = offset_q[4];
	assign key_ok     = {1'b0, key_index} < 7'(MAX_ROUNDS);
	assign last_round = round_q == num_rounds - 1'b1;

	// Round counts above the table depth saturate.
	always_comb begin
		if ({1'b0, round_count_q} > 7'(MAX_ROUNDS)) begin
			num_rounds = CW'(MAX_ROUNDS);
		end else begin
			num_rounds = CW'(round_count_q);
		end
	end

	assign ctr_rows.r0 = skn_pkg::bswap32(ctr_hi_q[63:32]);
	assign ctr_rows.r1 = skn_pkg::bswap32(ctr_hi_q[31:0]);
	assign ctr_rows.r2 = skn_pkg::bswap32(ctr_lo_q[63:32]);
	assign ctr_rows.r3 = skn_pkg::bswap32(ctr_lo_q[31:0]);

	assign ks_word = offset_q[3] ? ks_hi_q : ks_lo_q;
	assign ks_byte = 8'(ks_word >> {offset_q[2:0], 3'b000});

	skn_round u_round (
		.rows_in  (rows_q),
		.round_key(key_rd_q),
		.rows_out (rows_next)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			skn_pkg::ST_IDLE: begin
				if (in_acc && op_data && need_block) begin
					state_d = (num_rounds == '0) ? skn_pkg::ST_DONE : skn_pkg::ST_ROUND;
				end
			end
			skn_pkg::ST_ROUND: begin
				if (last_round) begin
					state_d = skn_pkg::ST_DONE;
				end
			end
			skn_pkg::ST_DONE: begin
				state_d = skn_pkg::ST_IDLE;
			end
			default: state_d = skn_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		in_stall = 1'b1;
		rd_addr  = '0;
		case (state_q)
			skn_pkg::ST_IDLE: begin
				in_stall = op_data && out_valid_q && out_stall;
			end
			skn_pkg::ST_ROUND: begin
				rd_addr = AW'(round_q + 1'b1);
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= skn_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_count_q <= skn_pkg::ROUND_COUNT_RESET;
		end else if (cfg_we) begin
			round_count_q <= cfg_wdata;
		end
	end

	// Round-key memory: keys are only written while no block is in progress,
	// so reads and writes never collide.
	always_ff @(posedge clk) begin
		if (in_acc && opcode == skn_pkg::OP_KEY && key_ok) begin
			key_mem[key_index[AW-1:0]] <= value;
		end
		key_rd_q <= key_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_hi_q <= '0;
			ctr_lo_q <= '0;
		end else if (state_q == skn_pkg::ST_DONE) begin
			{ctr_hi_q, ctr_lo_q} <= {ctr_hi_q, ctr_lo_q} + 128'd1;
		end else if (in_acc && opcode == skn_pkg::OP_CTR_HI) begin
			ctr_hi_q <= value;
		end else if (in_acc && opcode == skn_pkg::OP_CTR_LO) begin
			ctr_lo_q <= value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= 5'd16;
		end else if (state_q == skn_pkg::ST_DONE) begin
			offset_q <= 5'd1;
		end else if (in_acc) begin
			if (!op_data) begin
				offset_q <= 5'd16;
			end else if (!need_block) begin
				offset_q <= offset_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == skn_pkg::ST_IDLE) begin
			rows_q  <= ctr_rows;
			round_q <= '0;
			din_q   <= data_in;
		end else if (state_q == skn_pkg::ST_ROUND) begin
			rows_q  <= rows_next;
			round_q <= round_q + 1'b1;
		end
		if (state_q == skn_pkg::ST_DONE) begin
			ks_lo_q <= {rows_q.r1, rows_q.r0};
			ks_hi_q <= {rows_q.r3, rows_q.r2};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == skn_pkg::ST_DONE ||
		             (in_acc && op_data && !need_block)) begin
			out_valid_q <= 1'b1;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == skn_pkg::ST_DONE) begin
			data_out_q <= din_q ^ rows_q.r0[7:0];
		end else if (in_acc && op_data && !need_block) begin
			data_out_q <= data_in ^ ks_byte;
		end
	end

	assign out_valid = out_valid_q;
	assign data_out  = data_out_q;

endmodule

`default_nettype wire

### verif/testbench.sv
// ----------------------------------------------------------------------------
// SKINNY-128 CTR keystream engine testbench
// Drives key loads, counter writes and data bytes through the valid/stall
// input channel. It checks every output byte in order, against fixed values
// for the directed items and a local cipher model otherwise, over several
// round-count settings and with random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int KEY_DEPTH = skn_pkg::MAX_ROUNDS_DEF;
	localparam int DIR_N = 22;
	localparam int PHASE_N = 8;
	localparam int PHASE_ITEMS = 125;
	localparam int SETTLE_CYCLES = skn_pkg::MAX_ROUNDS_DEF + 8;

	typedef struct {
		skn_pkg::op_t op;
		logic [5:0]   idx;
		logic [63:0]  val;
		logic [7:0]   din;
		bit           fixed;
		logic [7:0]   exp_byte;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [5:0]  cfg_wdata;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  opcode;
	logic [5:0]  key_index;
	logic [63:0] value;
	logic [7:0]  data_in;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  data_out;

	// Local copy of the engine state.
	logic [63:0] key_tbl [KEY_DEPTH];
	logic [63:0] ctr_hi;
	logic [63:0] ctr_lo;
	logic [63:0] ks_lo;
	logic [63:0] ks_hi;
	int          ks_pos;
	logic [5:0]  rounds_cfg;

	logic [7:0]  expected_bytes [$];
	int          error_count;
	bit          quiet;
	dir_row_t    dir_tbl [DIR_N];

	skinny128_ctr_keystream i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.opcode    (opcode),
		.key_index (key_index),
		.value     (value),
		.data_in   (data_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.data_out  (data_out)
	);

	function automatic bit idle_now();
		return !quiet && ($urandom_range(99) < 28);
	endfunction

	function automatic logic [31:0] sbox_word(input logic [31:0] a);
		logic [31:0] x;
		logic [31:0] y;
		x = a;
		x = x ^ (~((x >> 2) | (x >> 3)) & 32'h1111_1111);
		y = ~((x << 5) | (x << 1)) & 32'h2020_2020;
		x = x ^ ((~((x << 5) | (x << 4)) & 32'h4040_4040) ^ y);
		y = ~((x << 2) | (x << 1)) & 32'h8080_8080;
		x = x ^ ((~((x >> 2) | (x << 1)) & 32'h0202_0202) ^ y);
		y = ~((x >> 5) | (x << 1)) & 32'h0404_0404;
		x = x ^ ((~((x >> 1) | (x >> 2)) & 32'h0808_0808) ^ y);
		return ((x & 32'h0808_0808) << 1) | ((x & 32'h3232_3232) << 2) |
		       ((x & 32'h0101_0101) << 5) | ((x & 32'h8080_8080) >> 6) |
		       ((x & 32'h4040_4040) >> 4) | ((x & 32'h0404_0404) >> 2);
	endfunction

	function automatic logic [31:0] row_of(input logic [31:0] w);
		return {w[7:0], w[15:8], w[23:16], w[31:24]};
	endfunction

	// Encrypts the counter into the keystream block, then bumps the counter.
	task automatic encrypt_counter();
		logic [31:0] r0, r1, r2, r3, t;
		logic [63:0] k;
		int n;
		r0 = row_of(ctr_hi[63:32]);
		r1 = row_of(ctr_hi[31:0]);
		r2 = row_of(ctr_lo[63:32]);
		r3 = row_of(ctr_lo[31:0]);
		n = (rounds_cfg > KEY_DEPTH) ? KEY_DEPTH : int'(rounds_cfg);
		for (int i = 0; i < n; i++) begin
			k = key_tbl[i];
			r0 = sbox_word(r0) ^ k[31:0];
			r1 = sbox_word(r1) ^ k[63:32];
			r2 = sbox_word(r2) ^ 32'h0000_0002;
			r3 = sbox_word(r3);
			r1 = {r1[23:0], r1[31:24]};
			r2 = {r2[15:0], r2[31:16]};
			r3 = {r3[7:0], r3[31:8]};
			r1 = r1 ^ r2;
			r2 = r2 ^ r0;
			t = r3 ^ r2;
			r3 = r2;
			r2 = r1;
			r1 = r0;
			r0 = t;
		end
		ks_lo = {r1, r0};
		ks_hi = {r3, r2};
		{ctr_hi, ctr_lo} = {ctr_hi, ctr_lo} + 128'd1;
	endtask

	// Applies one accepted item to the local state; returns 1 with the byte
	// for data items.
	task automatic predict_item(input skn_pkg::op_t op, input logic [5:0] idx,
	                            input logic [63:0] val, input logic [7:0] din,
	                            output bit has_out, output logic [7:0] out_byte);
		logic [7:0] ks;
		has_out = 0;
		out_byte = '0;
		case (op)
			skn_pkg::OP_KEY: begin
				if (idx < KEY_DEPTH)
					key_tbl[idx] = val;
				ks_pos = 16;
			end
			skn_pkg::OP_CTR_HI: begin
				ctr_hi = val;
				ks_pos = 16;
			end
			skn_pkg::OP_CTR_LO: begin
				ctr_lo = val;
				ks_pos = 16;
			end
			default: begin
				if (ks_pos >= 16) begin
					encrypt_counter();
					ks_pos = 0;
				end
				ks = (ks_pos < 8) ? ks_lo[8*ks_pos +: 8] : ks_hi[8*(ks_pos-8) +: 8];
				ks_pos++;
				has_out = 1;
				out_byte = din ^ ks;
			end
		endcase
	endtask

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_item(input skn_pkg::op_t op, input logic [5:0] idx,
	                         input logic [63:0] val, input logic [7:0] din,
	                         input bit fixed, input logic [7:0] fixed_exp);
		bit has_out;
		logic [7:0] pred;
		while (idle_now()) begin
			in_valid = 0;
			@(negedge clk);
		end
		in_valid = 1;
		opcode = op;
		key_index = idx;
		value = val;
		data_in = din;
		do
			@(posedge clk);
		while (in_stall);
		predict_item(op, idx, val, din, has_out, pred);
		if (has_out)
			expected_bytes.push_back(fixed ? fixed_exp : pred);
		@(negedge clk);
	endtask

	task automatic drain_results();
		in_valid = 0;
		while (expected_bytes.size() != 0)
			@(negedge clk);
		// Key and counter items leave no result behind, so give a round pass time.
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_rounds(input logic [5:0] rc);
		cfg_we = 1;
		cfg_wdata = rc;
		@(negedge clk);
		cfg_we = 0;
		rounds_cfg = rc;
	endtask

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("testbench NOT OK");
		$finish;
	end

	initial begin
		out_stall = 0;
		forever begin
			@(negedge clk);
			out_stall = idle_now();
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_bytes.size() == 0) begin
				$error("data_out: unexpected item, actual %02h", data_out);
				error_count++;
			end else begin
				if (data_out !== expected_bytes[0]) begin
					$error("data_out mismatch: expected %02h, actual %02h",
					       expected_bytes[0], data_out);
					error_count++;
				end
				void'(expected_bytes.pop_front());
			end
		end
	end

	initial begin
		logic [5:0]  phase_rc [6];
		logic [63:0] v;
		int sel;
		phase_rc = '{6'd40, 6'd48, 6'd56, 6'd63, 6'd1, 6'd0};

		// With zero rounds the keystream is the counter string itself, so most
		// expectations here are plain counter bytes.
		dir_tbl = '{
			'{skn_pkg::OP_CTR_HI, 6'd0,  64'h0001_0203_0405_0607, 8'h00, 1'b0, 8'h00},
			'{skn_pkg::OP_CTR_LO, 6'd0,  64'h0809_0A0B_0C0D_0E0F, 8'h00, 1'b0, 8'h00},
			'{skn_pkg::OP_DATA,   6'd0,  64'h0,                   8'h00, 1'b1, 8'h00},
			'{skn_pkg::OP_DATA,   6'd0,  64'h0,                   8'hFF, 1'b1, 8'hFE},
			'{skn_pkg::OP_DATA,   6'd0,  64'h0,                   8'h5A, 1'b1, 8'h58},
			'{skn_pkg::OP_KEY,    6'd63, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 8'h00},
			'{skn_pkg::OP_DATA,   6'd0,  64'h0,                   8'h00, 1'b1, 8'h00},
			'{skn_pkg::OP_DATA,   6'd0,  64'h0,                   8'h00, 1'b1, 8'h01},
			'{skn_pkg::OP_CTR_HI, 6'd0,  64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 8'h00},
			'{skn_pkg::OP_CTR_LO, 6'd0,  64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 8'h00},
			'{skn_pkg::OP_DATA,   6'd0,  64'h0,                   8'h00, 1'b1, 8'hFF},
			'{skn_pkg::OP_DATA,   6'd0,  64'h0,                   8'h0F, 1'b1, 8'hF0},
			'{skn_pkg::OP_KEY,    6'd0,  64'h0,                   8'h00, 1'b0, 8'h00},
			'{skn_pkg::OP_DATA,   6'd0,  64'h0,                   8'hA5, 1'b1, 8'hA5},
			'{skn_pkg::OP_DATA,   6'd0,  64'h0,                   8'h3C, 1'b1, 8'h3C},
			'{skn_pkg::OP_KEY,    6'd55, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 8'h00},
			'{skn_pkg::OP_KEY,    6'd56, 64'h0123_4567_89AB_CDEF, 8'h00, 1'b0, 8'h00},
			'{skn_pkg::OP_CTR_HI, 6'd0,  64'h0,                   8'h00, 1'b0, 8'h00},
			'{skn_pkg::OP_CTR_LO, 6'd0,  64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 8'h00},
			'{skn_pkg::OP_DATA,   6'd0,  64'h0,                   8'h00, 1'b1, 8'h00},
			'{skn_pkg::OP_KEY,    6'd42, 64'h5555_AAAA_3333_CCCC, 8'h00, 1'b0, 8'h00},
			'{skn_pkg::OP_DATA,   6'd0,  64'h0,                   8'h80, 1'b0, 8'h00}
		};

		error_count = 0;
		quiet = 0;
		arst_n = 0;
		cfg_we = 0;
		cfg_wdata = '0;
		in_valid = 0;
		opcode = skn_pkg::OP_KEY;
		key_index = '0;
		value = '0;
		data_in = '0;
		for (int i = 0; i < KEY_DEPTH; i++)
			key_tbl[i] = '0;
		ctr_hi = '0;
		ctr_lo = '0;
		ks_lo = '0;
		ks_hi = '0;
		ks_pos = 16;
		rounds_cfg = skn_pkg::ROUND_COUNT_RESET;
		repeat (4) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		write_rounds(6'd0);
		for (int i = 0; i < DIR_N; i++)
			send_item(dir_tbl[i].op, dir_tbl[i].idx, dir_tbl[i].val, dir_tbl[i].din,
			          dir_tbl[i].fixed, dir_tbl[i].exp_byte);

		// Every round key is loaded before any block uses more than zero rounds.
		drain_results();
		for (int i = 0; i < KEY_DEPTH; i++)
			send_item(skn_pkg::OP_KEY, 6'(i), {$urandom, $urandom}, 8'($urandom),
			          1'b0, 8'h00);

		for (int p = 0; p < PHASE_N; p++) begin
			drain_results();
			write_rounds((p < 6) ? phase_rc[p] : 6'($urandom_range(63)));
			quiet = (p == 2);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (p == 0 && n == 60) begin
					in_valid = 0;
					while (expected_bytes.size() != 0)
						@(negedge clk);
				end
				sel = $urandom_range(99);
				v = {$urandom, $urandom};
				if (sel < 72) begin
					send_item(skn_pkg::OP_DATA, 6'($urandom), v, 8'($urandom),
					          1'b0, 8'h00);
				end else if (sel < 80) begin
					send_item(skn_pkg::OP_KEY, 6'($urandom_range(63)), v, 8'($urandom),
					          1'b0, 8'h00);
				end else if (sel < 90) begin
					if ($urandom_range(3) == 0)
						v = ($urandom_range(1) == 0) ? '1 : '0;
					send_item(skn_pkg::OP_CTR_HI, 6'($urandom), v, 8'($urandom),
					          1'b0, 8'h00);
				end else begin
					// All ones in the low half forces a carry into the high half.
					if ($urandom_range(2) == 0)
						v = '1;
					send_item(skn_pkg::OP_CTR_LO, 6'($urandom), v, 8'($urandom),
					          1'b0, 8'h00);
				end
			end
			quiet = 0;
		end

		in_valid = 0;
		while (expected_bytes.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
